>>> hdl/efr_pkg.sv
// Shared types and constants for the ranked event frequency table.
// No dependencies; used by efr_cell and event_frequency_table_ranked.
`default_nettype none
package efr_pkg;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int USED_W          = 7;
  localparam int IDX_W           = 6;
  localparam int ID_W            = 16;
  localparam int COUNT_W         = 32;
  localparam int TOTAL_W         = 64;

  localparam logic [1:0] ST_RECORDED = 2'd0;
  localparam logic [1:0] ST_ENTRY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [IDX_W-1:0]   idx;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DN,
    CELL_LOAD,
    CELL_BUMP
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_ROT
  } state_t;
endpackage
`default_nettype wire

>>> hdl/event_frequency_table_ranked.sv
// Ranked event frequency table, top level.
// Depends on efr_pkg and efr_cell.
`default_nettype none
// The table is a row of TABLE_DEPTH cells kept in rank order whenever busy is
// low: descending count, equal counts in order of first appearance. A record
// request compares its identifier in every cell at once and answers on the
// next cycle. A hit bumps the cell and then runs a pass of odd-even neighbor
// swaps, with busy high, to move the bumped entry to its new rank; a new
// entry or a dropped one leaves busy low. A report request rotates the whole
// row once around with busy high, and presents the head cell each cycle:
// results come one per cycle, valid high, the first one once the state
// register has entered the rotation and the output registers have taken the
// head cell. The receiver cannot stall: every result is on the ports for
// exactly one cycle. An empty report answers like a record request. busy is
// low when a new request may be given with start.
module event_frequency_table_ranked #(
  parameter int TABLE_DEPTH = efr_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cmd,
  input  wire logic [15:0]                   event_id,
  input  wire logic [63:0]                   duration,
  input  wire logic [6:0]                    max_entries,
  output logic                               valid,
  output logic [1:0]                         status,
  output logic [15:0]                        entry_id,
  output logic [31:0]                        entry_count,
  output logic [63:0]                        entry_total,
  output logic                               last
);
  localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = efr_pkg::USED_W;

  efr_pkg::state_t state, state_next;
  logic [UW-1:0] used, used_next;
  logic [UW-1:0] emit, emit_next;
  logic [CW-1:0] step, step_next;

  efr_pkg::entry_t   cell_q  [TABLE_DEPTH];
  efr_pkg::cell_op_t cell_op [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match, hit, swap;
  efr_pkg::entry_t new_entry;

  logic accept, any_hit;
  logic [31:0] hit_count, bump_count;
  logic [63:0] hit_total;
  logic [UW-1:0] emit_calc;

  logic        valid_next, last_next;
  logic [1:0]  status_next;
  logic [15:0] id_next;
  logic [31:0] count_next;
  logic [63:0] total_next;

  // Row of cells; neighbors wrap so a full rotation restores the order
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    efr_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .up        (cell_q[(i + TABLE_DEPTH - 1) % TABLE_DEPTH]),
      .dn        (cell_q[(i + 1) % TABLE_DEPTH]),
      .new_entry (new_entry),
      .key       (event_id),
      .dur       (duration),
      .q         (cell_q[i]),
      .match     (match[i])
    );
  end

  assign accept    = start && !busy;
  assign busy      = (state != efr_pkg::S_IDLE);
  assign emit_calc = (used < max_entries) ? used : max_entries;

  always_comb begin
    new_entry.id    = event_id;
    new_entry.count = 32'd1;
    new_entry.total = duration;
    new_entry.idx   = used[efr_pkg::IDX_W-1:0];
  end

  // Hit lookup over the valid cells; at most one cell matches
  always_comb begin
    hit_count = '0;
    hit_total = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i] = match[i] && (UW'(i) < used);
      if (hit[i]) begin
        hit_count = hit_count | cell_q[i].count;
        hit_total = hit_total | cell_q[i].total;
      end
    end
    any_hit = |hit;
    bump_count = (hit_count == 32'hFFFF_FFFF) ? hit_count : hit_count + 32'd1;
  end

  // Odd-even swap decisions: pair i is cells i and i+1
  always_comb begin
    swap = '0;
    for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
      swap[i] = (state == efr_pkg::S_SORT) && (i[0] == step[0]) &&
                (UW'(i + 1) < used) &&
                ((cell_q[i].count < cell_q[i+1].count) ||
                 ((cell_q[i].count == cell_q[i+1].count) &&
                  (cell_q[i].idx > cell_q[i+1].idx)));
    end
  end

  // Cell operations
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cell_op[i] = efr_pkg::CELL_HOLD;
      case (state)
        efr_pkg::S_IDLE: begin
          if (accept && cmd == efr_pkg::CMD_RECORD) begin
            if (hit[i]) cell_op[i] = efr_pkg::CELL_BUMP;
            else if (!any_hit && UW'(i) == used) cell_op[i] = efr_pkg::CELL_LOAD;
          end
        end
        efr_pkg::S_SORT: begin
          if (swap[i]) cell_op[i] = efr_pkg::CELL_TAKE_DN;
          else if (i > 0 && swap[(i + TABLE_DEPTH - 1) % TABLE_DEPTH])
            cell_op[i] = efr_pkg::CELL_TAKE_UP;
        end
        efr_pkg::S_ROT: cell_op[i] = efr_pkg::CELL_TAKE_DN;
        default: cell_op[i] = efr_pkg::CELL_HOLD;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    used_next  = used;
    emit_next  = emit;
    case (state)
      efr_pkg::S_IDLE: begin
        step_next = '0;
        if (accept) begin
          if (cmd == efr_pkg::CMD_RECORD) begin
            if (any_hit) state_next = efr_pkg::S_SORT;
            else if (used < UW'(TABLE_DEPTH)) used_next = used + 1'b1;
          end else if (emit_calc != '0) begin
            emit_next  = emit_calc;
            state_next = efr_pkg::S_ROT;
          end
        end
      end
      efr_pkg::S_SORT, efr_pkg::S_ROT: begin
        step_next = step + 1'b1;
        if (step == CW'(TABLE_DEPTH - 1)) state_next = efr_pkg::S_IDLE;
      end
      default: state_next = efr_pkg::S_IDLE;
    endcase
  end

  // Result outputs
  always_comb begin
    valid_next  = 1'b0;
    status_next = efr_pkg::ST_RECORDED;
    id_next     = '0;
    count_next  = '0;
    total_next  = '0;
    last_next   = 1'b0;
    case (state)
      efr_pkg::S_IDLE: begin
        if (accept) begin
          valid_next = 1'b1;
          last_next  = 1'b1;
          if (cmd == efr_pkg::CMD_RECORD) begin
            id_next = event_id;
            if (any_hit) begin
              count_next = bump_count;
              total_next = hit_total + duration;
            end else if (used < UW'(TABLE_DEPTH)) begin
              count_next = 32'd1;
              total_next = duration;
            end else begin
              status_next = efr_pkg::ST_FULL;
            end
          end else if (emit_calc == '0) begin
            status_next = efr_pkg::ST_EMPTY;
          end else begin
            valid_next = 1'b0;
          end
        end
      end
      efr_pkg::S_ROT: begin
        // head cell holds rank step
        valid_next  = (UW'(step) < emit);
        status_next = efr_pkg::ST_ENTRY;
        id_next     = cell_q[0].id;
        count_next  = cell_q[0].count;
        total_next  = cell_q[0].total;
        last_next   = (UW'(step) + 1'b1 == emit);
      end
      default: valid_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efr_pkg::S_IDLE;
      used  <= '0;
      step  <= '0;
      emit  <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      step  <= step_next;
      emit  <= emit_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    status      <= status_next;
    entry_id    <= id_next;
    entry_count <= count_next;
    entry_total <= total_next;
    last        <= last_next;
  end
endmodule
`default_nettype wire

>>> hdl/efr_cell.sv
// One table cell: holds an entry, trades it with its neighbors, bumps it.
// Depends on efr_pkg.
`default_nettype none
module efr_cell (
  input  wire logic                        clk,
  input  wire efr_pkg::cell_op_t           op,
  input  wire efr_pkg::entry_t             up,
  input  wire efr_pkg::entry_t             dn,
  input  wire efr_pkg::entry_t             new_entry,
  input  wire logic [efr_pkg::ID_W-1:0]    key,
  input  wire logic [efr_pkg::TOTAL_W-1:0] dur,
  output efr_pkg::entry_t                  q,
  output logic                             match
);
  efr_pkg::entry_t q_next;

  assign match = (q.id == key);

  always_comb begin
    q_next = q;
    case (op)
      efr_pkg::CELL_HOLD:    q_next = q;
      efr_pkg::CELL_TAKE_UP: q_next = up;
      efr_pkg::CELL_TAKE_DN: q_next = dn;
      efr_pkg::CELL_LOAD:    q_next = new_entry;
      efr_pkg::CELL_BUMP: begin
        // saturate the count, wrap the total
        if (q.count != {efr_pkg::COUNT_W{1'b1}}) q_next.count = q.count + 1'b1;
        q_next.total = q.total + dur;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end
endmodule
`default_nettype wire

>>> sim/tb_event_frequency_table_ranked.sv
// Self-checking bench for event_frequency_table_ranked: record and report requests
// against an in-bench copy of the ranked table. Depends on efr_pkg and the top level RTL.
`timescale 1ns / 1ps
module tb_event_frequency_table_ranked;

  localparam int DEPTH = 64;

  // One expected answer of the block.
  typedef struct {
    logic [1:0]  status;
    logic [15:0] id;
    logic [31:0] count;
    logic [63:0] total;
    logic        last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cmd = efr_pkg::CMD_RECORD;
  logic [15:0] event_id = '0;
  logic [63:0] duration = '0;
  logic [6:0]  max_entries = '0;
  logic        busy;
  logic        valid;
  logic [1:0]  status;
  logic [15:0] entry_id;
  logic [31:0] entry_count;
  logic [63:0] entry_total;
  logic        last;

  // Shadow of the table, kept in insertion order like the block's rank rule needs.
  int          rows_used;
  logic [15:0] shadow_id[DEPTH];
  logic [31:0] shadow_count[DEPTH];
  logic [63:0] shadow_total[DEPTH];

  answer_t     pending_answers[$];
  int          mismatches;
  bit          idle_enable;
  logic [15:0] id_pool[24];

  event_frequency_table_ranked dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .event_id(event_id), .duration(duration), .max_entries(max_entries),
    .valid(valid), .status(status), .entry_id(entry_id),
    .entry_count(entry_count), .entry_total(entry_total), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Compute the answers to one accepted request and update the shadow table.
  task automatic rank_table_update(input logic c, input logic [15:0] id,
                                   input logic [63:0] dur, input logic [6:0] lim);
    answer_t a;
    int      order[DEPTH];
    int      emit, key, j;
    bit      hit;
    hit = 0;
    if (c == efr_pkg::CMD_RECORD) begin
      for (int i = 0; i < rows_used && !hit; i++) begin
        if (shadow_id[i] == id) begin
          hit = 1;
          // hold the count at its ceiling, let the total wrap
          if (shadow_count[i] != 32'hFFFF_FFFF) shadow_count[i]++;
          shadow_total[i] += dur;
          a = '{efr_pkg::ST_RECORDED, id, shadow_count[i], shadow_total[i], 1'b1};
        end
      end
      if (!hit) begin
        if (rows_used >= DEPTH) begin
          a = '{efr_pkg::ST_FULL, id, 32'd0, 64'd0, 1'b1};
        end else begin
          shadow_id[rows_used]    = id;
          shadow_count[rows_used] = 32'd1;
          shadow_total[rows_used] = dur;
          rows_used++;
          a = '{efr_pkg::ST_RECORDED, id, 32'd1, dur, 1'b1};
        end
      end
      pending_answers.push_back(a);
    end else begin
      emit = (rows_used < int'(lim)) ? rows_used : int'(lim);
      if (emit == 0) begin
        a = '{efr_pkg::ST_EMPTY, 16'd0, 32'd0, 64'd0, 1'b1};
        pending_answers.push_back(a);
      end else begin
        for (int i = 0; i < rows_used; i++) order[i] = i;
        // stable insertion: only strictly larger counts move ahead
        for (int i = 1; i < rows_used; i++) begin
          key = order[i];
          j = i;
          while (j > 0 && shadow_count[order[j-1]] < shadow_count[key]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = key;
        end
        for (int i = 0; i < emit; i++) begin
          a = '{efr_pkg::ST_ENTRY, shadow_id[order[i]], shadow_count[order[i]],
                shadow_total[order[i]], logic'(i + 1 == emit)};
          pending_answers.push_back(a);
        end
      end
    end
  endtask

  // Present one request and hold it until the block takes it. start is left
  // high; the next request or a pause decides what happens to it.
  task automatic send_request(input logic c, input logic [15:0] id,
                              input logic [63:0] dur, input logic [6:0] lim);
    start       <= 1'b1;
    cmd         <= c;
    event_id    <= id;
    duration    <= dur;
    max_entries <= lim;
    do @(posedge clk); while (busy);
    rank_table_update(c, id, dur, lim);
  endtask

  // Now and then, drop start for a pause.
  task automatic maybe_pause();
    if (idle_enable && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_duration();
    case ($urandom_range(3))
      0: rand_duration = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(255));
      1: rand_duration = 64'($urandom_range(1000));
      default: rand_duration = {$urandom, $urandom};
    endcase
  endfunction

  // Edges of the fields on an empty then tiny table: empty report, zero limit,
  // totals that wrap, limits above the table size and at the top of the field's range.
  task automatic test_directed();
    send_request(efr_pkg::CMD_REPORT, 16'h0000, 64'd0, 7'd10);
    send_request(efr_pkg::CMD_RECORD, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send_request(efr_pkg::CMD_RECORD, 16'hFFFF, 64'd1, 7'h7F);
    send_request(efr_pkg::CMD_RECORD, 16'h0000, 64'd2, 7'd0);
    send_request(efr_pkg::CMD_RECORD, 16'hA5A5, 64'h8000_0000_0000_0000, 7'd0);
    send_request(efr_pkg::CMD_RECORD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send_request(efr_pkg::CMD_RECORD, 16'h5A5A, 64'd0, 7'd0);
    send_request(efr_pkg::CMD_RECORD, 16'hFFFF, 64'd7, 7'd0);
    send_request(efr_pkg::CMD_REPORT, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
    send_request(efr_pkg::CMD_REPORT, 16'd0, 64'd0, 7'd1);
    send_request(efr_pkg::CMD_REPORT, 16'd0, 64'd0, 7'd64);
    send_request(efr_pkg::CMD_REPORT, 16'd0, 64'd0, 7'h7F);
    send_request(efr_pkg::CMD_REPORT, 16'd0, 64'd0, 7'd3);
  endtask

  // Mostly hits on a small pool so the ranking moves; reports now and then.
  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      maybe_pause();
      if ($urandom_range(6) == 0)
        send_request(efr_pkg::CMD_REPORT, 16'($urandom), {$urandom, $urandom},
                     7'($urandom_range(127)));
      else if ($urandom_range(9) == 0)
        send_request(efr_pkg::CMD_RECORD, 16'($urandom), rand_duration(),
                     7'($urandom));
      else
        send_request(efr_pkg::CMD_RECORD, id_pool[$urandom_range(23)],
                     rand_duration(), 7'($urandom));
    end
  endtask

  // Fill every free row with new identifiers, then knock on the full table.
  task automatic test_table_full();
    logic [15:0] fresh;
    bit          seen;
    while (rows_used < DEPTH) begin
      maybe_pause();
      fresh = 16'($urandom);
      send_request(efr_pkg::CMD_RECORD, fresh, rand_duration(), 7'd0);
    end
    send_request(efr_pkg::CMD_REPORT, 16'd0, 64'd0, 7'd64);
    for (int k = 0; k < 6; k++) begin
      do begin
        fresh = 16'($urandom);
        seen = 0;
        for (int i = 0; i < DEPTH; i++) if (shadow_id[i] == fresh) seen = 1;
      end while (seen);
      send_request(efr_pkg::CMD_RECORD, fresh, rand_duration(), 7'd0);
      send_request(efr_pkg::CMD_RECORD, shadow_id[$urandom_range(DEPTH-1)],
                   rand_duration(), 7'd0);
    end
    send_request(efr_pkg::CMD_REPORT, 16'd0, 64'd0, 7'h7F);
  endtask

  // Compare every strobed result with the oldest expected one.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && valid) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: status %0d id %h", status, entry_id);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (entry_id !== want.id) begin
          $error("entry_id: expected %h, got %h", want.id, entry_id);
          mismatches++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          mismatches++;
        end
        if (entry_total !== want.total) begin
          $error("entry_total: expected %h, got %h", want.total, entry_total);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, got %b", want.last, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rows_used   = 0;
    mismatches  = 0;
    idle_enable = 1;
    foreach (id_pool[i]) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(200);
    // let every answer come back before carrying on
    wait_drained();
    test_table_full();
    idle_enable = 0;
    test_random(60);

    wait_drained();
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> filelist.f
hdl/efr_pkg.sv
hdl/efr_cell.sv
hdl/event_frequency_table_ranked.sv
sim/tb_event_frequency_table_ranked.sv
